// ----- src/xbf_pkg.sv -----
// xbf_pkg: shared types, constants and helper functions for the xmodem block framer
// used by xbf_ctrl, xbf_dp and xmodem_block_framer_core; no dependencies
`timescale 1ns / 1ps

package xbf_pkg;

    // data bytes per block
    localparam int BLOCK_BYTES = 128;
    // fill counter must be able to hold BLOCK_BYTES itself
    localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);

    localparam logic [7:0]  SOH_BYTE = 8'h01;
    localparam logic [7:0]  EOT_BYTE = 8'h04;
    localparam logic [7:0]  PAD_BYTE = 8'h1A;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BLOCK_BYTES - 1);

    // input opcodes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    // configuration space
    localparam int         ADDR_W        = 2;
    localparam logic [ADDR_W-1:0] REG_CRC_MODE = ADDR_W'(0);
    localparam logic       CRC_MODE_RESET = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] repeat_count;
        logic       last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SOH,
        ST_NUM,
        ST_INV,
        ST_DATA,
        ST_PAD,
        ST_PAD_CRC,
        ST_TRL_HI,
        ST_TRL_LO,
        ST_EOT1,
        ST_EOT2
    } state_t;

    // output byte source
    typedef enum logic [3:0] {
        SEL_SOH,
        SEL_NUM,
        SEL_INV,
        SEL_DATA,
        SEL_PAD,
        SEL_SUM,
        SEL_CRC_HI,
        SEL_CRC_LO,
        SEL_EOT
    } sel_t;

    typedef struct packed {
        logic emit;        // load output register
        sel_t sel;
        logic last;
        logic latch_in;    // capture accepted input transaction
        logic feed_data;   // fold latched byte into sum and crc
        logic feed_pad;    // fold one padding byte into sum and crc
        logic close_block; // next block number, clear block state
        logic restart;     // back to block 1, clear block state
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic fill_zero;
        logic fill_full;   // current byte completes the block
        logic eof;
    } status_t;

    // one byte through crc-16/xmodem, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // padding run length, kept to eight bits
    function automatic logic [7:0] pad_repeat(input logic [FILL_W-1:0] fill);
        logic [31:0] n;
        n = 32'(BLOCK_BYTES) - 32'(fill);
        return n[7:0];
    endfunction

endpackage

// ----- src/xbf_ctrl.sv -----
// xbf_ctrl: sequencer for one input transaction of the framer
// depends on xbf_pkg
`timescale 1ns / 1ps

module xbf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             crc_mode,
    input  xbf_pkg::status_t status,
    output xbf_pkg::cmd_t    cmd
);

    xbf_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= xbf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        cmd             = '0;
        cmd.sel         = xbf_pkg::SEL_DATA;
        unique case (state_reg)
            xbf_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.latch_in = s_valid;
                if (s_valid) begin
                    state_next = xbf_pkg::ST_DISPATCH;
                end
            end
            xbf_pkg::ST_DISPATCH: begin
                if (status.eof) begin
                    state_next = status.fill_zero ? xbf_pkg::ST_EOT1 : xbf_pkg::ST_PAD;
                end else begin
                    state_next = status.fill_zero ? xbf_pkg::ST_SOH : xbf_pkg::ST_DATA;
                end
            end
            xbf_pkg::ST_SOH: begin
                cmd.sel = xbf_pkg::SEL_SOH;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = xbf_pkg::ST_NUM;
                end
            end
            xbf_pkg::ST_NUM: begin
                cmd.sel = xbf_pkg::SEL_NUM;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = xbf_pkg::ST_INV;
                end
            end
            xbf_pkg::ST_INV: begin
                cmd.sel = xbf_pkg::SEL_INV;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = xbf_pkg::ST_DATA;
                end
            end
            xbf_pkg::ST_DATA: begin
                cmd.sel  = xbf_pkg::SEL_DATA;
                cmd.last = !status.fill_full;
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.feed_data = 1'b1;
                    state_next    = status.fill_full ? xbf_pkg::ST_TRL_HI : xbf_pkg::ST_IDLE;
                end
            end
            xbf_pkg::ST_PAD: begin
                cmd.sel = xbf_pkg::SEL_PAD;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = xbf_pkg::ST_PAD_CRC;
                end
            end
            xbf_pkg::ST_PAD_CRC: begin
                // one padding byte per cycle until the block is full
                cmd.feed_pad = 1'b1;
                if (status.fill_full) begin
                    state_next = xbf_pkg::ST_TRL_HI;
                end
            end
            xbf_pkg::ST_TRL_HI: begin
                cmd.sel  = crc_mode ? xbf_pkg::SEL_CRC_HI : xbf_pkg::SEL_SUM;
                cmd.last = !crc_mode && !status.eof;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (crc_mode) begin
                        state_next = xbf_pkg::ST_TRL_LO;
                    end else if (status.eof) begin
                        state_next = xbf_pkg::ST_EOT1;
                    end else begin
                        cmd.close_block = 1'b1;
                        state_next      = xbf_pkg::ST_IDLE;
                    end
                end
            end
            xbf_pkg::ST_TRL_LO: begin
                cmd.sel  = xbf_pkg::SEL_CRC_LO;
                cmd.last = !status.eof;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.eof) begin
                        state_next = xbf_pkg::ST_EOT1;
                    end else begin
                        cmd.close_block = 1'b1;
                        state_next      = xbf_pkg::ST_IDLE;
                    end
                end
            end
            xbf_pkg::ST_EOT1: begin
                cmd.sel = xbf_pkg::SEL_EOT;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = xbf_pkg::ST_EOT2;
                end
            end
            xbf_pkg::ST_EOT2: begin
                cmd.sel  = xbf_pkg::SEL_EOT;
                cmd.last = 1'b1;
                if (status.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.restart = 1'b1;
                    state_next  = xbf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = xbf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/xbf_dp.sv -----
// xbf_dp: block state, checksum and crc accumulators, output register
// depends on xbf_pkg; driven by xbf_ctrl
`timescale 1ns / 1ps

module xbf_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  xbf_pkg::in_item_t   s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output xbf_pkg::out_item_t  m_payload,
    input  xbf_pkg::cmd_t       cmd,
    output xbf_pkg::status_t    status
);

    xbf_pkg::in_item_t          in_reg;
    logic [7:0]                 block_number_reg, block_number_next;
    logic [xbf_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]                 sum_reg, sum_next;
    logic [15:0]                crc_reg, crc_next;
    logic                       out_valid_reg, out_valid_next;
    xbf_pkg::out_item_t         out_reg, out_next;
    logic [7:0]                 feed_byte;

    assign feed_byte = cmd.feed_pad ? xbf_pkg::PAD_BYTE : in_reg.data_byte;

    always_comb begin
        block_number_next = block_number_reg;
        fill_next         = fill_reg;
        sum_next          = sum_reg;
        crc_next          = crc_reg;
        priority if (cmd.restart) begin
            block_number_next = 8'd1;
            fill_next         = '0;
            sum_next          = '0;
            crc_next          = '0;
        end else if (cmd.close_block) begin
            block_number_next = block_number_reg + 8'd1;
            fill_next         = '0;
            sum_next          = '0;
            crc_next          = '0;
        end else if (cmd.feed_data || cmd.feed_pad) begin
            fill_next = fill_reg + 1'b1;
            sum_next  = sum_reg + feed_byte;
            crc_next  = xbf_pkg::crc_feed(crc_reg, feed_byte);
        end else begin
            fill_next = fill_reg;
        end
    end

    always_comb begin
        out_next              = out_reg;
        out_next.repeat_count = 8'd1;
        out_next.last         = cmd.last;
        unique case (cmd.sel)
            xbf_pkg::SEL_SOH:    out_next.out_byte = xbf_pkg::SOH_BYTE;
            xbf_pkg::SEL_NUM:    out_next.out_byte = block_number_reg;
            xbf_pkg::SEL_INV:    out_next.out_byte = ~block_number_reg;
            xbf_pkg::SEL_DATA:   out_next.out_byte = in_reg.data_byte;
            xbf_pkg::SEL_PAD: begin
                out_next.out_byte     = xbf_pkg::PAD_BYTE;
                out_next.repeat_count = xbf_pkg::pad_repeat(fill_reg);
            end
            xbf_pkg::SEL_SUM:    out_next.out_byte = sum_reg;
            xbf_pkg::SEL_CRC_HI: out_next.out_byte = crc_reg[15:8];
            xbf_pkg::SEL_CRC_LO: out_next.out_byte = crc_reg[7:0];
            xbf_pkg::SEL_EOT:    out_next.out_byte = xbf_pkg::EOT_BYTE;
            default:             out_next.out_byte = xbf_pkg::EOT_BYTE;
        endcase
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_number_reg <= 8'd1;
            fill_reg         <= '0;
            sum_reg          <= '0;
            crc_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            block_number_reg <= block_number_next;
            fill_reg         <= fill_next;
            sum_reg          <= sum_next;
            crc_reg          <= crc_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            in_reg <= s_payload;
        end
        if (cmd.emit) begin
            out_reg <= out_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    assign status.out_free  = !out_valid_reg || m_ready;
    assign status.fill_zero = (fill_reg == '0);
    assign status.fill_full = (fill_reg == xbf_pkg::FILL_LAST);
    assign status.eof       = (in_reg.opcode == xbf_pkg::OP_EOF);

endmodule

// ----- src/xmodem_block_framer_core.sv -----
// xmodem_block_framer_core: top level of the xmodem sender block framer
// depends on xbf_pkg, xbf_ctrl and xbf_dp
`timescale 1ns / 1ps

// Turns a file byte stream into xmodem blocks. Each input transaction carries
// either a data byte or an end-of-file mark; each output transaction carries
// one byte to send with a repeat count (above one only for the ctrl-z padding
// run) and a last flag on the final byte caused by that input. A block opens
// with soh, the block number and its complement, and closes with an 8-bit sum
// or a crc-16/xmodem (high byte first), chosen by crc_mode at byte address 0
// (reset 1). Items are handled one at a time by the sequencer: a data byte
// passes through idle, dispatch and data, plus a state per extra header or
// trailer byte. End of file with a partial block walks the crc one pad byte a
// cycle, since the crc step in the datapath takes a single byte per update.
module xmodem_block_framer_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_valid,
    output logic                           s_ready,
    input  xbf_pkg::in_item_t              s_payload,
    // output stream
    output logic                           m_valid,
    input  logic                           m_ready,
    output xbf_pkg::out_item_t             m_payload,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [xbf_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    xbf_pkg::cmd_t    cmd;
    xbf_pkg::status_t status;

    // trailer mode register; the user must write it only between transactions, the block does not enforce this
    logic crc_mode_reg, crc_mode_next;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == xbf_pkg::REG_CRC_MODE);

    always_comb begin
        crc_mode_next = cfg_write ? pwdata[0] : crc_mode_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_mode_reg <= xbf_pkg::CRC_MODE_RESET;
        end else begin
            crc_mode_reg <= crc_mode_next;
        end
    end

    // read back; unmapped addresses read as zero
    assign prdata = (paddr == xbf_pkg::REG_CRC_MODE) ? {31'd0, crc_mode_reg} : 32'd0;

    // sequencer
    xbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .crc_mode (crc_mode_reg),
        .status   (status),
        .cmd      (cmd)
    );

    // block state, accumulators and output register
    xbf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
